@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the escaper RTL
// Clocked concurrent checks, disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a consequent holds in the same cycle as its trigger.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/jsesc_pkg.sv @@
// ---------------------------------------------------------------------------
// jsesc_pkg
// Types and constants shared by the JSON string escaper controller and datapath.
// ---------------------------------------------------------------------------
package jsesc_pkg;

  // controller -> datapath commands
  typedef struct packed {
    logic load;   // capture an accepted word behind the held bytes
    logic emit;   // produce one output byte
    logic stash;  // park the unfinished sequence at the window head
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic hold_now;   // window head is an unfinished sequence
    logic tok_end;    // current byte closes its token
    logic step_last;  // current token is the last one of this word
    logic out_free;   // output register can take a byte this cycle
  } sts_t;

  // token kinds at the window head
  localparam logic [2:0] K_ONE  = 3'd0;  // byte passes as is
  localparam logic [2:0] K_ESC  = 3'd1;  // two-character escape
  localparam logic [2:0] K_HEX  = 3'd2;  // \uXXXX escape
  localparam logic [2:0] K_UTF  = 3'd3;  // valid multi-byte sequence
  localparam logic [2:0] K_HOLD = 3'd4;  // sequence still incomplete

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  tlen;  // output bytes in the token
    logic [2:0]  adv;   // input bytes consumed by the token
    logic [15:0] v;     // escape char or hex value
  } dec_t;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // UTF-8 structure
  localparam logic [7:0] MASK_E0 = 8'hE0;
  localparam logic [7:0] MASK_F0 = 8'hF0;
  localparam logic [7:0] MASK_F8 = 8'hF8;
  localparam logic [7:0] MASK_C0 = 8'hC0;
  localparam logic [7:0] CONT_80 = 8'h80;

  localparam logic [15:0] REPL_CP  = 16'hFFFD;
  localparam logic [20:0] MIN_CP2  = 21'h000080;
  localparam logic [20:0] MIN_CP3  = 21'h000800;
  localparam logic [20:0] MIN_CP4  = 21'h010000;
  localparam logic [20:0] SURR_LO  = 21'h00D800;
  localparam logic [20:0] SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] MAX_CP   = 21'h10FFFF;

endpackage

@@ rtl/utf8_sanitizing_json_string_escaper_unit.sv @@
// ---------------------------------------------------------------------------
// utf8_sanitizing_json_string_escaper_unit
// Escapes a raw byte string into JSON string text, replacing malformed UTF-8.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  in_byte, in_final_byte
//  out      source     out_valid/out_stall  out_byte, out_run_last, out_text_end
//
//  Flow: a word is taken while the sequencer is idle, then its results leave
//  one byte per cycle while out_stall allows, 0 to 24 bytes; a word that only
//  extends a held sequence gives none. The byte sequencer in jsesc_ctrl sets this.
//  Reset: synchronous, active low; clears the held count and output valid.
//  Stalls: out_stall holds back byte emission; in_stall is high while a word is
//  expanding, and drops as soon as its last byte sits in the output register.
//
// Each word is appended behind up to three held bytes of an unfinished UTF-8
// sequence. The datapath classifies the token at the head of that window,
// emits it byte by byte, advances, and parks a trailing incomplete sequence
// for the next word. Malformed leads turn into \ufffd and the bytes behind
// them are examined again.
// ---------------------------------------------------------------------------
module utf8_sanitizing_json_string_escaper_unit import jsesc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, expand, park
  jsesc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window, decoder and output register
  jsesc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_byte       (in_byte),
    .in_final_byte (in_final_byte),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_end  (out_text_end)
  );

endmodule

@@ rtl/jsesc_ctrl.sv @@
// ---------------------------------------------------------------------------
// jsesc_ctrl
// Two-state sequencer: take a word, then drive the datapath until done.
// ---------------------------------------------------------------------------
module jsesc_ctrl import jsesc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic done;

  always_comb begin
    cmd       = '0;
    done      = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.stash = sts.hold_now;
        cmd.emit  = !sts.hold_now && sts.out_free;
        done      = cmd.stash || (cmd.emit && sts.tok_end && sts.step_last);
        if (done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/jsesc_dp.sv @@
// ---------------------------------------------------------------------------
// jsesc_dp
// Byte window, token decoder, held-sequence store and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jsesc_dp import jsesc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [7:0] in_byte,
  input  logic       in_final_byte,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end
);

  logic [7:0] buf_r [4];
  logic [7:0] held_r [3];
  logic [1:0] held_cnt_r;
  logic [2:0] len_r, pos_r, k_r;
  logic       fin_r;
  logic       out_valid_r, out_last_r, out_end_r;
  logic [7:0] out_byte_r;

  logic [7:0] cur_w [4];
  logic [7:0] nxt_w [4];
  logic [2:0] cur_avail, nxt_avail, pos_adv;
  dec_t       cur_d, nxt_d;
  logic       nxt_hold, step_last, tok_end, out_free;
  logic [7:0] emit_byte;

  function automatic logic [7:0] hexd(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    else           return 8'h57 + {4'h0, n};
  endfunction

  // classify the token that starts at w0
  function automatic dec_t decide(input logic [7:0] w0, input logic [7:0] w1,
                                  input logic [7:0] w2, input logic [7:0] w3,
                                  input logic [2:0] avail, input logic fin);
    dec_t        d;
    logic [2:0]  need, upto;
    logic        ok;
    logic [20:0] cp;
    d    = '{kind: K_ONE, tlen: 3'd1, adv: 3'd1, v: {8'h00, w0}};
    need = 3'd0;
    upto = 3'd0;
    ok   = 1'b1;
    cp   = '0;
    if (!w0[7]) begin
      case (w0)
        CH_QUOTE, CH_BSL: begin d.kind = K_ESC; d.tlen = 3'd2; end
        CH_LF:  begin d.kind = K_ESC; d.tlen = 3'd2; d.v = {8'h00, CH_N}; end
        CH_CR:  begin d.kind = K_ESC; d.tlen = 3'd2; d.v = {8'h00, CH_R}; end
        CH_TAB: begin d.kind = K_ESC; d.tlen = 3'd2; d.v = {8'h00, CH_T}; end
        default: begin
          if (w0 < CH_SPACE || w0 == CH_DEL) begin
            d.kind = K_HEX;
            d.tlen = 3'd6;
          end
        end
      endcase
    end else begin
      if ((w0 & MASK_E0) == MASK_C0)      need = 3'd2;
      else if ((w0 & MASK_F0) == MASK_E0) need = 3'd3;
      else if ((w0 & MASK_F8) == MASK_F0) need = 3'd4;
      upto = (avail < need) ? avail : need;
      if (upto > 3'd1 && (w1 & MASK_C0) != CONT_80) ok = 1'b0;
      if (upto > 3'd2 && (w2 & MASK_C0) != CONT_80) ok = 1'b0;
      if (upto > 3'd3 && (w3 & MASK_C0) != CONT_80) ok = 1'b0;
      case (need)
        3'd2: cp = {10'h000, w0[4:0], w1[5:0]};
        3'd3: cp = {5'h00, w0[3:0], w1[5:0], w2[5:0]};
        3'd4: cp = {w0[2:0], w1[5:0], w2[5:0], w3[5:0]};
        default: cp = '0;
      endcase
      if (need == 3'd0) begin
        ok = 1'b0;
      end else if (ok && avail < need && !fin) begin
        d.kind = K_HOLD;
      end else begin
        if (avail < need) ok = 1'b0;
        if (need == 3'd2 && cp < MIN_CP2) ok = 1'b0;
        if (need == 3'd3 && (cp < MIN_CP3 || (cp >= SURR_LO && cp <= SURR_HI))) ok = 1'b0;
        if (need == 3'd4 && (cp < MIN_CP4 || cp > MAX_CP)) ok = 1'b0;
      end
      if (d.kind != K_HOLD) begin
        if (ok) begin
          d.kind = K_UTF;
          d.tlen = need;
          d.adv  = need;
        end else begin
          d.kind = K_HEX;
          d.tlen = 3'd6;
          d.v    = REPL_CP;
        end
      end
    end
    return d;
  endfunction

  // build the byte window at the current position and after this token
  always_comb begin
    logic [2:0] ci, ni;
    cur_avail = len_r - pos_r;
    cur_d = '0;
    for (int j = 0; j < 4; j++) begin
      ci = pos_r + 3'(j);
      cur_w[j] = ci[2] ? 8'h00 : buf_r[ci[1:0]];
    end
    cur_d = decide(cur_w[0], cur_w[1], cur_w[2], cur_w[3], cur_avail, fin_r);
    pos_adv   = pos_r + cur_d.adv;
    nxt_avail = len_r - pos_adv;
    for (int j = 0; j < 4; j++) begin
      ni = pos_adv + 3'(j);
      nxt_w[j] = ni[2] ? 8'h00 : buf_r[ni[1:0]];
    end
  end

  assign nxt_d     = decide(nxt_w[0], nxt_w[1], nxt_w[2], nxt_w[3], nxt_avail, fin_r);
  assign nxt_hold  = (pos_adv < len_r) && (nxt_d.kind == K_HOLD);
  assign step_last = (pos_adv >= len_r) || nxt_hold;
  assign tok_end   = (k_r == cur_d.tlen - 3'd1);
  assign out_free  = !out_valid_r || !out_stall;

  // byte k of the current token
  always_comb begin
    emit_byte = cur_d.v[7:0];
    case (cur_d.kind)
      K_ONE: emit_byte = cur_d.v[7:0];
      K_ESC: emit_byte = (k_r == 3'd0) ? CH_BSL : cur_d.v[7:0];
      K_HEX: begin
        case (k_r)
          3'd0:    emit_byte = CH_BSL;
          3'd1:    emit_byte = CH_U;
          3'd2:    emit_byte = hexd(cur_d.v[15:12]);
          3'd3:    emit_byte = hexd(cur_d.v[11:8]);
          3'd4:    emit_byte = hexd(cur_d.v[7:4]);
          default: emit_byte = hexd(cur_d.v[3:0]);
        endcase
      end
      K_UTF: emit_byte = cur_w[k_r[1:0]];
      default: emit_byte = cur_d.v[7:0];
    endcase
  end

  always_comb begin
    sts.hold_now  = (cur_d.kind == K_HOLD);
    sts.tok_end   = tok_end;
    sts.step_last = step_last;
    sts.out_free  = out_free;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r  <= 2'd0;
      len_r       <= 3'd0;
      pos_r       <= 3'd0;
      k_r         <= 3'd0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        held_cnt_r <= 2'd0;
        len_r      <= {1'b0, held_cnt_r} + 3'd1;
        pos_r      <= 3'd0;
        k_r        <= 3'd0;
        fin_r      <= in_final_byte;
      end
      if (cmd.stash) held_cnt_r <= cur_avail[1:0];
      if (cmd.emit) begin
        if (tok_end) begin
          pos_r <= pos_adv;
          k_r   <= 3'd0;
          if (nxt_hold) held_cnt_r <= nxt_avail[1:0];
        end else begin
          k_r <= k_r + 3'd1;
        end
      end
      if (cmd.emit)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < 4; j++) begin
        if (j < 3 && 2'(j) < held_cnt_r) buf_r[j] <= held_r[j % 3];
        else if (3'(j) == {1'b0, held_cnt_r}) buf_r[j] <= in_byte;
      end
    end
    if (cmd.stash) begin
      for (int j = 0; j < 3; j++) held_r[j] <= cur_w[j];
    end else if (cmd.emit && tok_end && nxt_hold) begin
      for (int j = 0; j < 3; j++) held_r[j] <= nxt_w[j];
    end
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= tok_end && step_last;
      out_end_r  <= tok_end && step_last && fin_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;
  assign out_text_end = out_end_r;

  `ASSERT_IMPL(a_k_in_token, clk, rst_n, cmd.emit, k_r < cur_d.tlen, "token index overran")
  `ASSERT_IMPL(a_pos_in_word, clk, rst_n, cmd.emit, pos_r < len_r, "emit past end of word")
  `ASSERT_NEXT(a_load_clears, clk, rst_n, cmd.load, held_cnt_r == 2'd0, "held count not cleared")
  `ASSERT_IMPL(a_no_fin_hold, clk, rst_n, cmd.stash, !fin_r, "sequence held after final byte")

endmodule

@@ tb/json_escape_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// json_escape_checker
// Watches both channels of the JSON string escaper, predicts the escaped
// text of every accepted input word and compares each output word with it.
// ---------------------------------------------------------------------------
module json_escape_checker import jsesc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_final_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_run_last,
  input  logic       out_text_end,
  output int         failures,
  output int         pending,
  output int         bytes_checked
);

  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_A_LOWER   = 8'h61;
  localparam logic [7:0] CONT_PAYLOAD = 8'h3F;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } esc_word_t;

  esc_word_t  expected_text [$];
  logic [7:0] held [3];
  int         held_n;

  function automatic void push_plain(input logic [7:0] b);
    esc_word_t w;
    w.data     = b;
    w.run_last = 1'b0;
    w.text_end = 1'b0;
    expected_text.push_back(w);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + {4'h0, nib};
    return CH_A_LOWER + {4'h0, nib} - 8'd10;
  endfunction

  function automatic void push_hex(input logic [15:0] v);
    push_plain(CH_BSL);
    push_plain(CH_U);
    push_plain(hex_char(v[15:12]));
    push_plain(hex_char(v[11:8]));
    push_plain(hex_char(v[7:4]));
    push_plain(hex_char(v[3:0]));
  endfunction

  function automatic void push_ascii(input logic [7:0] c);
    case (c)
      CH_QUOTE: begin push_plain(CH_BSL); push_plain(CH_QUOTE); end
      CH_BSL:   begin push_plain(CH_BSL); push_plain(CH_BSL); end
      CH_LF:    begin push_plain(CH_BSL); push_plain(CH_N); end
      CH_CR:    begin push_plain(CH_BSL); push_plain(CH_R); end
      CH_TAB:   begin push_plain(CH_BSL); push_plain(CH_T); end
      default: begin
        if (c < CH_SPACE || c == CH_DEL) push_hex({8'h00, c});
        else push_plain(c);
      end
    endcase
  endfunction

  function automatic int seq_length(input logic [7:0] c);
    if ((c & MASK_E0) == MASK_C0) return 2;
    if ((c & MASK_F0) == MASK_E0) return 3;
    if ((c & MASK_F8) == MASK_F0) return 4;
    return 0;
  endfunction

  // Append the word behind the held bytes, escape the window, park a
  // trailing unfinished sequence unless the string ends here.
  function automatic void escape_word(input logic [7:0] b, input logic fin);
    logic [7:0]  win [4];
    logic [20:0] cp;
    logic [20:0] floor_cp;
    logic [7:0]  c;
    logic        ok;
    int          n, pos, need, avail, upto, k, first;
    esc_word_t   tail;
    n = 0;
    pos = 0;
    first = expected_text.size();
    for (k = 0; k < held_n; k++) begin
      win[n] = held[k];
      n++;
    end
    win[n] = b;
    n++;
    held_n = 0;
    while (pos < n) begin
      c = win[pos];
      need = seq_length(c);
      if (c < 8'h80) begin
        push_ascii(c);
        pos++;
      end else if (need == 0) begin
        push_hex(REPL_CP);
        pos++;
      end else begin
        avail = n - pos;
        upto = (avail < need) ? avail : need;
        ok = 1'b1;
        for (k = 1; k < upto; k++)
          if ((win[pos + k] & MASK_C0) != CONT_80) ok = 1'b0;
        if (ok && avail < need && !fin) begin
          for (k = 0; k < avail; k++) held[k] = win[pos + k];
          held_n = avail;
          pos = n;
        end else begin
          if (avail < need) ok = 1'b0;
          if (ok) begin
            cp = {13'h0, c & (8'hFF >> (need + 1))};
            for (k = 1; k < need; k++)
              cp = (cp << 6) | {13'h0, win[pos + k] & CONT_PAYLOAD};
            floor_cp = (need == 2) ? MIN_CP2 : (need == 3) ? MIN_CP3 : MIN_CP4;
            if (cp < floor_cp || (cp >= SURR_LO && cp <= SURR_HI) || cp > MAX_CP)
              ok = 1'b0;
          end
          if (ok) begin
            for (k = 0; k < need; k++) push_plain(win[pos + k]);
            pos += need;
          end else begin
            push_hex(REPL_CP);
            pos++;
          end
        end
      end
    end
    if (expected_text.size() > first) begin
      tail = expected_text[expected_text.size() - 1];
      tail.run_last = 1'b1;
      tail.text_end = fin;
      expected_text[expected_text.size() - 1] = tail;
    end
  endfunction

  always @(posedge clk) begin : watch
    esc_word_t want;
    if (!rst_n) begin
      expected_text.delete();
      held_n = 0;
    end else begin
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (expected_text.size() == 0) begin
          failures++;
          $error("out_byte: expected nothing, got 8'h%02h", out_byte);
        end else begin
          want = expected_text.pop_front();
          if (out_byte !== want.data) begin
            failures++;
            $error("out_byte: expected 8'h%02h, got 8'h%02h", want.data, out_byte);
          end
          if (out_run_last !== want.run_last) begin
            failures++;
            $error("out_run_last: expected %b, got %b", want.run_last, out_run_last);
          end
          if (out_text_end !== want.text_end) begin
            failures++;
            $error("out_text_end: expected %b, got %b", want.text_end, out_text_end);
          end
        end
      end
      if (in_valid && !in_stall) escape_word(in_byte, in_final_byte);
    end
    pending <= expected_text.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives byte strings into the UTF-8 sanitizing JSON string escaper: a
// directed string of escapes and malformed sequences, then random strings
// built mostly from well-formed UTF-8 with broken sequences mixed in, under
// random sender gaps and receiver stalls. A checker predicts and compares.
// ---------------------------------------------------------------------------
module testbench import jsesc_pkg::*;;

  localparam int ITEMS          = 400;  // input words to send, roughly
  localparam int QUIET_TAIL     = 60;   // last words sent with no idling at all
  localparam int SETTLE_CYCLES  = 40;   // longer than one word's full expansion
  localparam int WATCHDOG_LIMIT = 1000; // cycles without any handshake

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_text_end;

  int failures;
  int pending;
  int bytes_checked;

  // Idling knobs and counters; the stimulus changes quiet and stall_pct once per string.
  logic quiet = 1'b0;
  int   stall_pct = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;

  int words_sent = 0;
  int strings_sent = 0;
  int cut_strings = 0;

  logic [7:0] str_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  utf8_sanitizing_json_string_escaper_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_end  (out_text_end)
  );

  json_escape_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_end  (out_text_end),
    .failures      (failures),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  // Receiver stalls come in bursts whose extra length is drawn into stall_left. A
  // new burst starts only while out_stall is low, so the receiver always releases between bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && !out_stall && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Code point in [lo, hi], with the range ends picked now and then.
  function automatic logic [20:0] pick_cp(input logic [20:0] lo, input logic [20:0] hi);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 21'($urandom_range(lo, hi));
  endfunction

  // Encode cp in len bytes, lead byte in the top eight bits. Longer forms
  // than needed give overlong encodings on purpose.
  function automatic logic [31:0] utf8_encode(input logic [20:0] cp, input int len);
    case (len)
      2:       return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
      3:       return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
      4:       return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                       2'b10, cp[5:0]};
      default: return {1'b0, cp[6:0], 24'h0};
    endcase
  endfunction

  function automatic logic [20:0] valid_cp(input int len);
    logic [20:0] cp;
    case (len)
      2: cp = pick_cp(21'h80, 21'h7FF);
      3: begin
        do cp = pick_cp(MIN_CP3, 21'hFFFF);
        while (cp >= SURR_LO && cp <= SURR_HI);
      end
      default: cp = pick_cp(MIN_CP4, MAX_CP);
    endcase
    return cp;
  endfunction

  function automatic void push_seq(input logic [31:0] enc, input int keep);
    int k;
    for (k = 0; k < keep; k++) str_q.push_back(enc[31 - 8 * k -: 8]);
  endfunction

  // Append one token: mostly well-formed text, the rest broken on purpose.
  function automatic void add_token();
    logic [31:0] enc;
    logic [7:0]  spoil;
    int          r, len, at;
    r = $urandom_range(0, 99);
    len = $urandom_range(2, 4);
    if (r < 30) begin
      str_q.push_back(8'($urandom_range(0, 8'h7F)));
    end else if (r < 40) begin
      // characters with their own escapes
      case ($urandom_range(0, 6))
        0: str_q.push_back(CH_QUOTE);
        1: str_q.push_back(CH_BSL);
        2: str_q.push_back(CH_LF);
        3: str_q.push_back(CH_CR);
        4: str_q.push_back(CH_TAB);
        5: str_q.push_back(CH_DEL);
        default: str_q.push_back(8'($urandom_range(0, 8'h1F)));
      endcase
    end else if (r < 74) begin
      push_seq(utf8_encode(valid_cp(len), len), len);
    end else if (r < 78) begin
      // overlong: a code point that fits in fewer bytes
      enc = utf8_encode((len == 2) ? pick_cp(21'h0, 21'h7F) :
                        (len == 3) ? pick_cp(21'h0, 21'h7FF) : pick_cp(21'h0, 21'hFFFF),
                        len);
      push_seq(enc, len);
    end else if (r < 81) begin
      push_seq(utf8_encode(pick_cp(SURR_LO, SURR_HI), 3), 3);
    end else if (r < 84) begin
      push_seq(utf8_encode(pick_cp(MAX_CP + 21'd1, 21'h1FFFFF), 4), 4);
    end else if (r < 89) begin
      // one continuation byte replaced by something that is not one
      enc = utf8_encode(valid_cp(len), len);
      at = $urandom_range(1, len - 1);
      spoil = 8'($urandom_range(0, 1) ? $urandom_range(0, 8'h7F)
                                      : $urandom_range(8'hC0, 8'hFF));
      enc[31 - 8 * at -: 8] = spoil;
      push_seq(enc, len);
    end else if (r < 93) begin
      // stray continuation, or a lead that no sequence uses
      str_q.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF)
                                              : $urandom_range(8'hF8, 8'hFF)));
    end else begin
      str_q.push_back(8'($urandom_range(0, 8'hFF)));
    end
  endfunction

  function automatic void build_text();
    int n_tok, len;
    str_q.delete();
    n_tok = $urandom_range(1, 10);
    repeat (n_tok) add_token();
    // sometimes end the string inside a sequence
    if ($urandom_range(0, 99) < 15) begin
      len = $urandom_range(2, 4);
      push_seq(utf8_encode(valid_cp(len), len), $urandom_range(1, len - 1));
      cut_strings++;
    end
  endfunction

  // Present one word and hold it until accepted. Called at a rising edge.
  task automatic send_word(input logic [7:0] b, input logic fin, input int gap_pct);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(input int gap_pct);
    int k;
    for (k = 0; k < str_q.size(); k++)
      send_word(str_q[k], k == str_q.size() - 1, gap_pct);
    strings_sent++;
  endtask

  // Hold the input idle until every predicted byte has come out. The count
  // is registered, so look only from the edge after the last acceptance.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int   gap_pct;
    logic paused_mid;
    paused_mid = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed string: every escape, NUL and DEL, a stray continuation, an
    // unusable lead, a good two-byte sequence, an overlong one, a surrogate,
    // a code point above the Unicode range, a bad continuation, and a string
    // cut off inside a three-byte sequence.
    str_q = '{CH_QUOTE, CH_BSL, CH_LF, CH_CR, CH_TAB, 8'h00, CH_DEL,
              8'h80, 8'hFF,
              8'hC3, 8'hA9,
              8'hC0, 8'h80,
              8'hED, 8'hA0, 8'h80,
              8'hF4, 8'h90, 8'h80, 8'h80,
              8'hE2, 8'h41,
              8'hE2, 8'h82};
    send_text(0);
    drain();

    while (words_sent < ITEMS) begin
      if (words_sent >= ITEMS - QUIET_TAIL) quiet <= 1'b1;
      // per string: sometimes no idling, sometimes light, sometimes heavy
      case ($urandom_range(0, 2))
        0: begin gap_pct = 0; stall_pct <= 0; end
        1: begin gap_pct = 20; stall_pct <= 15; end
        default: begin gap_pct = 50; stall_pct <= 40; end
      endcase
      build_text();
      send_text(gap_pct);
      if (!paused_mid && words_sent >= ITEMS / 2) begin
        drain();
        paused_mid = 1'b1;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d strings and %0d input words, %0d escaped bytes checked;",
             strings_sent, words_sent, bytes_checked);
    $display("%0d random strings ended inside a multi-byte sequence.", cut_strings);
    if (failures == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
